>>> hw/rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared types and constants for the square-and-multiply exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

    // Width of the external payload and configuration data ports.
    localparam int FIELD_W = 32;

    // Configuration register index.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SKIP,
        ST_SQ,
        ST_SQ_WAIT,
        ST_BM,
        ST_BM_WAIT,
        ST_NEXT,
        ST_FIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // capture message, set accumulator to one
        logic shift;         // advance to the next exponent bit
        logic mul_base_sel;  // multiplier takes the message instead of the accumulator
        logic red_start;     // launch a multiply and reduction
        logic acc_load;      // accumulator takes the remainder
        logic out_load;      // result register takes the accumulator
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic exp_msb;       // current exponent bit
        logic cnt_zero;      // no exponent bits remain
        logic cnt_last;      // current bit is bit 0
        logic red_done;      // reduction finished, remainder valid
        logic out_free;      // result register can take a new value
    } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Raises each message word to a configured exponent modulo a configured
// modulus, using left-to-right square and multiply.
// ----------------------------------------------------------------------------
// Usage: write the exponent (index 0) and the modulus (index 1) through the
// cfg_* port while the block is idle. Each input transaction on s_* carries
// one message word; one output transaction on m_* returns the word raised to
// the exponent and reduced by the modulus. A zero exponent returns 1.
// Sequence: after acceptance, leading zero exponent bits are skipped. Each
// modular multiplication is done by the shared reduction unit, which
// retires two remainder bits per cycle. Every exponent bit from the top set
// bit down costs one squaring plus a step state (ST_NEXT), and a one bit
// adds a multiplication by the message.
// One item is processed at a time. The result sits in an output register, so
// the next transaction is accepted while a previous result waits for m_ready.
// A result that finds the output register still full waits there until the
// receiver takes the old one.
// Reset clears the exponent to 0, the modulus to 2 and drops any work.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write port.
    input  wire logic                              cfg_wr_en,
    input  wire logic [mexp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mexp_pkg::FIELD_W-1:0]      cfg_data,
    // Message input channel.
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [mexp_pkg::FIELD_W-1:0]      s_message_word,
    // Result output channel.
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [mexp_pkg::FIELD_W-1:0]           m_power_result
);

    mexp_pkg::cmd_t    cmd;
    mexp_pkg::status_t status;

    // The controller sequences the exponent scan; it sees only status flags.
    mexp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the key, the operands, the multiplier, the
    // reduction unit and the output register.
    mexp_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .message_word (s_message_word),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .power_result (m_power_result),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

>>> hw/rtl/mexp_reduce.sv
// ----------------------------------------------------------------------------
// Modular reduction unit
// Restoring remainder of a double-width product, two bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_reduce #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [2*OPERAND_WIDTH-1:0]   product,
    input  wire logic [OPERAND_WIDTH-1:0]     modulus,
    output logic                              done,
    output logic [OPERAND_WIDTH-1:0]          remainder
);

    localparam int W      = OPERAND_WIDTH;
    localparam int STEP_W = $clog2(W + 1);

    logic [2*W-1:0]    prod_sh_reg, prod_sh_next;
    logic [W-1:0]      rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    // Two restoring steps per cycle. With a zero modulus the compare always
    // passes and the subtract is a no-op, leaving the low product bits.
    always_comb begin
        logic [W:0]     trial;
        logic [W-1:0]   r;
        logic [2*W-1:0] p;
        r = rem_reg;
        p = prod_sh_reg;
        for (int k = 0; k < 2; k++) begin
            trial = {r, p[2*W-1]};
            p     = {p[2*W-2:0], 1'b0};
            if (trial >= {1'b0, modulus}) begin
                trial = trial - {1'b0, modulus};
            end
            r = trial[W-1:0];
        end
        rem_next     = r;
        prod_sh_next = p;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(W);
            end else if (busy_reg) begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            prod_sh_reg <= product;
            rem_reg     <= '0;
        end else if (busy_reg) begin
            prod_sh_reg <= prod_sh_next;
            rem_reg     <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    a_start_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && step_reg == STEP_W'(W))
        else $error("reduction did not start with a full step count");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("reduction done while still busy");

    a_busy_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> step_reg != '0)
        else $error("reduction busy with no steps left");

endmodule

`default_nettype wire

>>> hw/rtl/mexp_datapath.sv
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Key registers, operand registers, multiplier, reduction unit and result.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_datapath #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mexp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mexp_pkg::FIELD_W-1:0]      cfg_data,
    input  wire logic [mexp_pkg::FIELD_W-1:0]      message_word,
    input  wire logic                              m_ready,
    output logic                                   m_valid,
    output logic [mexp_pkg::FIELD_W-1:0]           power_result,
    input  wire mexp_pkg::cmd_t                    cmd,
    output mexp_pkg::status_t                      status
);

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     exp_cfg_reg;
    logic [W-1:0]     mod_cfg_reg;
    logic [W-1:0]     base_reg;
    logic [W-1:0]     acc_reg;
    logic [W-1:0]     exp_sh_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     res_reg;
    logic             out_valid_reg;

    logic [W-1:0]     mul_b;
    logic [2*W-1:0]   product;
    logic [W-1:0]     remainder;
    logic             red_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_cfg_reg <= '0;
            mod_cfg_reg <= W'(2);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mexp_pkg::REG_EXPONENT: exp_cfg_reg <= cfg_data[W-1:0];
                mexp_pkg::REG_MODULUS:  mod_cfg_reg <= cfg_data[W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.load) begin
            cnt_reg <= CNT_W'(W);
        end else if (cmd.shift) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            base_reg   <= message_word[W-1:0];
            acc_reg    <= W'(1);
            exp_sh_reg <= exp_cfg_reg;
        end else begin
            if (cmd.shift) begin
                exp_sh_reg <= {exp_sh_reg[W-2:0], 1'b0};
            end
            if (cmd.acc_load) begin
                acc_reg <= remainder;
            end
        end
        if (cmd.out_load) begin
            res_reg <= acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // The product is registered inside the reduction unit.
    assign mul_b   = cmd.mul_base_sel ? base_reg : acc_reg;
    assign product = {{W{1'b0}}, acc_reg} * {{W{1'b0}}, mul_b};

    mexp_reduce #(
        .OPERAND_WIDTH (W)
    ) u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.red_start),
        .product   (product),
        .modulus   (mod_cfg_reg),
        .done      (red_done),
        .remainder (remainder)
    );

    always_comb begin
        status.exp_msb  = exp_sh_reg[W-1];
        status.cnt_zero = (cnt_reg == '0);
        status.cnt_last = (cnt_reg == CNT_W'(1));
        status.red_done = red_done;
        status.out_free = !out_valid_reg || m_ready;
    end

    assign m_valid      = out_valid_reg;
    assign power_result = mexp_pkg::FIELD_W'(res_reg);

endmodule

`default_nettype wire

>>> hw/rtl/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences the exponent scan, square and multiply steps and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mexp_pkg::status_t status,
    output mexp_pkg::cmd_t         cmd
);

    mexp_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mexp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            mexp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = mexp_pkg::ST_SKIP;
                end
            end
            // Skip leading zero bits of the exponent.
            mexp_pkg::ST_SKIP: begin
                priority if (status.cnt_zero) begin
                    state_next = mexp_pkg::ST_FIN;
                end else if (status.exp_msb) begin
                    state_next = mexp_pkg::ST_SQ;
                end else begin
                    cmd.shift = 1'b1;
                end
            end
            mexp_pkg::ST_SQ: begin
                cmd.red_start = 1'b1;
                state_next    = mexp_pkg::ST_SQ_WAIT;
            end
            mexp_pkg::ST_SQ_WAIT: begin
                if (status.red_done) begin
                    cmd.acc_load = 1'b1;
                    state_next   = status.exp_msb ? mexp_pkg::ST_BM : mexp_pkg::ST_NEXT;
                end
            end
            mexp_pkg::ST_BM: begin
                cmd.red_start    = 1'b1;
                cmd.mul_base_sel = 1'b1;
                state_next       = mexp_pkg::ST_BM_WAIT;
            end
            mexp_pkg::ST_BM_WAIT: begin
                if (status.red_done) begin
                    cmd.acc_load = 1'b1;
                    state_next   = mexp_pkg::ST_NEXT;
                end
            end
            mexp_pkg::ST_NEXT: begin
                cmd.shift  = 1'b1;
                state_next = status.cnt_last ? mexp_pkg::ST_FIN : mexp_pkg::ST_SQ;
            end
            mexp_pkg::ST_FIN: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = mexp_pkg::ST_IDLE;
                end
            end
            default: state_next = mexp_pkg::ST_IDLE;
        endcase
    end

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        status.red_done |-> (state_reg == mexp_pkg::ST_SQ_WAIT ||
                             state_reg == mexp_pkg::ST_BM_WAIT))
        else $error("reduction finished outside a wait state");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result overwritten before it was taken");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == mexp_pkg::ST_SKIP)
        else $error("accepted transaction did not start the exponent scan");

endmodule

`default_nettype wire
